// ----- rtl/bcd_adjust_unit_macros.svh -----
// assertion macros for the bcd adjust unit checker
// needs clk_i and rst_ni in the scope of each use
`ifndef BCD_ADJUST_UNIT_MACROS_SVH
`define BCD_ADJUST_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bcd_pkg.sv -----
// types, constants and helper functions for the bcd adjust unit
// no dependencies
package bcd_pkg;

  typedef enum logic [2:0] {
    ACT_DAA = 3'd0,
    ACT_DAS = 3'd1,
    ACT_AAA = 3'd2,
    ACT_AAS = 3'd3,
    ACT_AAM = 3'd4,
    ACT_AAD = 3'd5
  } action_e;

  localparam logic [15:0] FLAG_CF = 16'h0001;
  localparam logic [15:0] FLAG_PF = 16'h0004;
  localparam logic [15:0] FLAG_AF = 16'h0010;
  localparam logic [15:0] FLAG_ZF = 16'h0040;
  localparam logic [15:0] FLAG_SF = 16'h0080;

  localparam int unsigned CF_POS = 0;
  localparam int unsigned AF_POS = 4;

  localparam logic [15:0] MASK_DEC   = FLAG_CF | FLAG_PF | FLAG_AF | FLAG_ZF | FLAG_SF;
  localparam logic [15:0] MASK_ASCII = FLAG_CF | FLAG_AF;
  localparam logic [15:0] MASK_DIV   = FLAG_PF | FLAG_ZF | FLAG_SF;

  localparam logic [7:0]  LOW_ADJ   = 8'h06;
  localparam logic [7:0]  HIGH_ADJ  = 8'h60;
  localparam logic [7:0]  DAA_LIMIT = 8'h9F;
  localparam logic [7:0]  DAS_LIMIT = 8'h99;
  localparam logic [3:0]  NIB_LIMIT = 4'h9;
  localparam logic [15:0] ASCII_ADJ  = 16'h0106;
  localparam logic [15:0] ASCII_KEEP = 16'hFF0F;

  // after the first stage
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ax;
    logic        cf;
    logic        adj;
    logic        lowc;
    logic        das_hi;
    logic [7:0]  a1;
    logic [7:0]  prod;
    logic [7:0]  quo;
    logic [7:0]  rem;
    logic [7:0]  base;
  } s1_t;

  // after the second stage
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] part;
    logic [15:0] mask;
    logic        derr;
  } s2_t;

  // one restoring divide step: {quotient bit, new remainder}
  function automatic logic [8:0] div_step(logic [7:0] rem, logic din, logic [7:0] dvs);
    logic [8:0] t;
    logic [8:0] d;
    t = {rem, din};
    d = {1'b0, dvs};
    if (t >= d) begin
      div_step = {1'b1, 8'(t - d)};
    end else begin
      div_step = {1'b0, t[7:0]};
    end
  endfunction

  // sign, zero and parity of a byte
  function automatic logic [15:0] szp(logic [7:0] v);
    logic [15:0] f;
    f = '0;
    if (v == 8'h00) begin
      f = f | FLAG_ZF;
    end
    if (v[7]) begin
      f = f | FLAG_SF;
    end
    if (!(^v)) begin
      f = f | FLAG_PF;
    end
    szp = f;
  endfunction

endpackage

// ----- rtl/bcd_if.sv -----
// item channels of the bcd adjust unit: request and result
// no dependencies
interface bcd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] ax_in;
  logic [15:0] flags_in;
  logic [7:0]  base;

  modport source (output valid, action, ax_in, flags_in, base, input ready);
  modport sink   (input valid, action, ax_in, flags_in, base, output ready);
endinterface

interface bcd_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] ax_out;
  logic [15:0] flag_bits;
  logic [15:0] flag_mask;
  logic        div_fault;

  modport source (output valid, ax_out, flag_bits, flag_mask, div_fault, input ready);
  modport sink   (input valid, ax_out, flag_bits, flag_mask, div_fault, output ready);
endinterface

// ----- rtl/bcd_pre.sv -----
// first stage: low decimal correction, aad multiply, upper quotient bits
// depends on bcd_pkg and bcd_req_if
module bcd_pre import bcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcd_req_if.sink    item_i,
  output logic       valid_o,
  output s1_t        data_o,
  input  logic       ready_i
);

  logic       valid_q, valid_d;
  s1_t        data_q, data_d;
  logic       load;
  logic [7:0] al;
  logic [8:0] sum;
  logic [15:0] prod;
  logic [7:0] rem_v;
  logic [7:0] quo_v;
  logic [8:0] step;

  assign item_i.ready = !valid_q || ready_i;
  assign load         = item_i.valid && item_i.ready;
  assign al           = item_i.ax_in[7:0];
  assign sum          = {1'b0, al} + {1'b0, LOW_ADJ};
  assign prod         = item_i.ax_in[15:8] * item_i.base;

  always_comb begin
    data_d        = '0;
    data_d.op     = item_i.action;
    data_d.ax     = item_i.ax_in;
    data_d.base   = item_i.base;
    data_d.cf     = item_i.flags_in[CF_POS];
    data_d.adj    = (al[3:0] > NIB_LIMIT) || item_i.flags_in[AF_POS];
    data_d.das_hi = al > DAS_LIMIT;
    data_d.prod   = prod[7:0];
    data_d.a1     = al;
    data_d.lowc   = 1'b0;
    case (item_i.action)
      ACT_DAA: begin
        if (data_d.adj) begin
          data_d.a1   = sum[7:0];
          data_d.lowc = sum[8];
        end
      end
      ACT_DAS: begin
        if (data_d.adj) begin
          data_d.a1   = al - LOW_ADJ;
          data_d.lowc = al < LOW_ADJ;
        end
      end
      default: ;
    endcase
    // upper four quotient bits
    rem_v = '0;
    quo_v = '0;
    step  = '0;
    for (int i = 7; i >= 4; i--) begin
      step     = div_step(rem_v, al[i], item_i.base);
      quo_v[i] = step[8];
      rem_v    = step[7:0];
    end
    data_d.quo = quo_v;
    data_d.rem = rem_v;
  end

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/bcd_mid.sv -----
// second stage: high correction, ascii adjust, aad add, lower quotient bits
// depends on bcd_pkg
module bcd_mid import bcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  s1_t  data_i,
  output logic ready_o,
  output logic valid_o,
  output s2_t  data_o,
  input  logic ready_i
);

  logic       valid_q, valid_d;
  s2_t        data_q, data_d;
  logic       load;
  logic       c;
  logic [7:0] a2;
  logic [15:0] asc;
  logic [7:0] rem_v;
  logic [7:0] quo_v;
  logic [8:0] step;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    rem_v = data_i.rem;
    quo_v = data_i.quo;
    step  = '0;
    for (int i = 3; i >= 0; i--) begin
      step     = div_step(rem_v, data_i.ax[i], data_i.base);
      quo_v[i] = step[8];
      rem_v    = step[7:0];
    end
  end

  always_comb begin
    data_d      = '0;
    data_d.ax   = data_i.ax;
    c           = 1'b0;
    a2          = data_i.a1;
    asc         = data_i.ax;
    case (data_i.op) inside
      ACT_DAA: begin
        c = (data_i.a1 > DAA_LIMIT) || data_i.cf || data_i.lowc;
        if (c) begin
          a2 = data_i.a1 + HIGH_ADJ;
        end
        data_d.ax   = {data_i.ax[15:8], a2};
        data_d.mask = MASK_DEC;
        data_d.part = (data_i.adj ? FLAG_AF : '0) | (c ? FLAG_CF : '0);
      end
      ACT_DAS: begin
        c = data_i.das_hi || data_i.cf || data_i.lowc;
        if (c) begin
          a2 = data_i.a1 - HIGH_ADJ;
        end
        data_d.ax   = {data_i.ax[15:8], a2};
        data_d.mask = MASK_DEC;
        data_d.part = (data_i.adj ? FLAG_AF : '0) | (c ? FLAG_CF : '0);
      end
      ACT_AAA, ACT_AAS: begin
        if (data_i.adj) begin
          if (data_i.op == ACT_AAA) begin
            asc = data_i.ax + ASCII_ADJ;
          end else begin
            asc = data_i.ax - ASCII_ADJ;
          end
        end
        data_d.ax   = asc & ASCII_KEEP;
        data_d.mask = MASK_ASCII;
        data_d.part = data_i.adj ? MASK_ASCII : '0;
      end
      ACT_AAM: begin
        if (data_i.base == 8'h00) begin
          data_d.derr = 1'b1;
        end else begin
          data_d.ax   = {quo_v, rem_v};
          data_d.mask = MASK_DIV;
        end
      end
      ACT_AAD: begin
        data_d.ax   = {8'h00, data_i.prod + data_i.ax[7:0]};
        data_d.mask = MASK_DIV;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/bcd_fin.sv -----
// last stage: sign, zero and parity of the new al, flag merge, result register
// depends on bcd_pkg and bcd_rsp_if
module bcd_fin import bcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  s2_t     data_i,
  output logic    ready_o,
  bcd_rsp_if.source result_o
);

  logic        valid_q, valid_d;
  logic        load;
  logic [15:0] ax_q;
  logic [15:0] bits_q, bits_d;
  logic [15:0] mask_q;
  logic        derr_q;

  assign ready_o = !valid_q || result_o.ready;
  assign load    = valid_i && ready_o;
  assign bits_d  = (szp(data_i.ax[7:0]) | data_i.part) & data_i.mask;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ax_q   <= data_i.ax;
      bits_q <= bits_d;
      mask_q <= data_i.mask;
      derr_q <= data_i.derr;
    end
  end

  assign result_o.valid     = valid_q;
  assign result_o.ax_out    = ax_q;
  assign result_o.flag_bits = bits_q;
  assign result_o.flag_mask = mask_q;
  assign result_o.div_fault = derr_q;

endmodule

// ----- rtl/bcd_adjust_unit.sv -----
// top level of the bcd adjust unit: three-stage pipeline of x86 decimal adjusts
// depends on bcd_pkg, bcd_req_if, bcd_rsp_if, bcd_pre, bcd_mid, bcd_fin
//
//   channel   dir   handshake     payload
//   item_i    in    valid/ready   action, ax_in, flags_in, base
//   result_o  out   valid/ready   ax_out, flag_bits, flag_mask, div_fault
//
// result registered through the pre, mid and fin stages in turn; one item per
// cycle sustained while result_o is ready
// the aam divide runs four restoring steps in each of the first two stages
// each stage holds its own valid bit and loads when it is empty or drains
// a stalled result holds in the output register while earlier stages keep filling
// reset clears the valid bits only
module bcd_adjust_unit import bcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcd_req_if.sink   item_i,
  bcd_rsp_if.source result_o
);

  logic s1_valid, s1_ready;
  s1_t  s1_data;
  logic s2_valid, s2_ready;
  s2_t  s2_data;

  bcd_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s1_ready)
  );

  bcd_mid u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s1_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (s2_ready)
  );

  bcd_fin u_fin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .data_i   (s2_data),
    .ready_o  (s2_ready),
    .result_o (result_o)
  );

endmodule

// ----- rtl/bcd_chk.sv -----
// port-level checks on the bcd adjust unit result channel, bound to the top level
// depends on bcd_pkg and bcd_adjust_unit_macros.svh
`include "bcd_adjust_unit_macros.svh"

module bcd_chk import bcd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] ax_out_i,
  input logic [15:0] flag_bits_i,
  input logic [15:0] flag_mask_i,
  input logic        div_fault_i
);

  `BCD_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable({ax_out_i, flag_bits_i, flag_mask_i}), "result changed while stalled")
  `BCD_ASSERT_NOW(a_bits_in_mask, out_valid_i, (flag_bits_i & ~flag_mask_i) == 16'h0000, "flag bits outside mask")
  `BCD_ASSERT_NOW(a_derr_mask, out_valid_i && div_fault_i, flag_mask_i == 16'h0000, "divide fault with flags written")
  `BCD_ASSERT_NOW(a_mask_kind, out_valid_i, flag_mask_i == MASK_DEC || flag_mask_i == MASK_ASCII || flag_mask_i == MASK_DIV || flag_mask_i == 16'h0000, "unexpected flag mask")

endmodule

bind bcd_adjust_unit bcd_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .ax_out_i    (result_o.ax_out),
  .flag_bits_i (result_o.flag_bits),
  .flag_mask_i (result_o.flag_mask),
  .div_fault_i (result_o.div_fault)
);

// ----- tb/sv/bcd_adjust_unit_chk.sv -----
// result checker for the bcd adjust unit: watches both item channels,
// computes each expected result and compares it field by field
// depends on bcd_pkg
module bcd_adjust_unit_chk import bcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [2:0]  action_i,
  input  logic [15:0] ax_i,
  input  logic [15:0] flags_i,
  input  logic [7:0]  base_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [15:0] ax_out_i,
  input  logic [15:0] flag_bits_i,
  input  logic [15:0] flag_mask_i,
  input  logic        div_fault_i,
  input  logic        end_i,
  output int          pending_o,
  output int          checked_o,
  output int          errors_o
);

  localparam int PRINT_CAP = 30;

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] bits;
    logic [15:0] mask;
    logic        derr;
  } adjust_t;

  adjust_t adjust_q[$];
  int      err_cnt = 0;
  int      checked = 0;
  bit      end_seen = 1'b0;

  initial begin
    pending_o = 0;
    checked_o = 0;
    errors_o  = 0;
  end

  // sign, zero and parity of the new al
  function automatic logic [15:0] byte_flags(logic [7:0] v);
    logic [15:0] f;
    f = '0;
    if (v == 8'h00) f = f | FLAG_ZF;
    if (v[7]) f = f | FLAG_SF;
    if (^v == 1'b0) f = f | FLAG_PF;
    return f;
  endfunction

  function automatic adjust_t adjust_result(logic [2:0] op, logic [15:0] ax,
                                            logic [15:0] fl, logic [7:0] bs);
    adjust_t     r;
    logic [7:0]  al;
    logic [7:0]  ah;
    logic [7:0]  a;
    logic [8:0]  sum;
    logic [15:0] prod;
    logic        cf;
    logic        adj;
    logic        lowc;
    logic        hic;
    al   = ax[7:0];
    ah   = ax[15:8];
    a    = al;
    cf   = fl[CF_POS];
    adj  = (al[3:0] > NIB_LIMIT) || fl[AF_POS];
    lowc = 1'b0;
    r    = '{ax: ax, bits: '0, mask: '0, derr: 1'b0};
    case (op)
      ACT_DAA: begin
        if (adj) begin
          sum  = {1'b0, a} + {1'b0, LOW_ADJ};
          lowc = sum[8];
          a    = sum[7:0];
        end
        hic = (a > DAA_LIMIT) || cf || lowc;
        if (hic) a = a + HIGH_ADJ;
        r.ax   = {ah, a};
        r.mask = MASK_DEC;
        r.bits = byte_flags(a) | (adj ? FLAG_AF : 16'h0) | (hic ? FLAG_CF : 16'h0);
      end
      ACT_DAS: begin
        if (adj) begin
          lowc = a < LOW_ADJ;
          a    = a - LOW_ADJ;
        end
        hic = (al > DAS_LIMIT) || cf || lowc;
        if (hic) a = a - HIGH_ADJ;
        r.ax   = {ah, a};
        r.mask = MASK_DEC;
        r.bits = byte_flags(a) | (adj ? FLAG_AF : 16'h0) | (hic ? FLAG_CF : 16'h0);
      end
      ACT_AAA, ACT_AAS: begin
        if (adj) r.ax = (op == ACT_AAA) ? ax + ASCII_ADJ : ax - ASCII_ADJ;
        r.ax   = r.ax & ASCII_KEEP;
        r.mask = MASK_ASCII;
        r.bits = adj ? MASK_ASCII : 16'h0;
      end
      ACT_AAM: begin
        if (bs == 8'h00) begin
          r.derr = 1'b1;
        end else begin
          r.ax   = {al / bs, al % bs};
          r.mask = MASK_DIV;
          r.bits = byte_flags(r.ax[7:0]);
        end
      end
      ACT_AAD: begin
        prod   = {8'h00, ah} * {8'h00, bs} + {8'h00, al};
        r.ax   = {8'h00, prod[7:0]};
        r.mask = MASK_DIV;
        r.bits = byte_flags(prod[7:0]);
      end
      default: begin
      end
    endcase
    r.bits = r.bits & r.mask;
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    if (err_cnt < PRINT_CAP) begin
      $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
    end
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    adjust_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        adjust_q.push_back(adjust_result(action_i, ax_i, flags_i, base_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (adjust_q.size() == 0) begin
          report("result with none pending, ax", ax_out_i, 16'h0);
        end else begin
          want = adjust_q.pop_front();
          if (ax_out_i !== want.ax) report("ax_out", ax_out_i, want.ax);
          if (flag_bits_i !== want.bits) report("flag_bits", flag_bits_i, want.bits);
          if (flag_mask_i !== want.mask) report("flag_mask", flag_mask_i, want.mask);
          if (div_fault_i !== want.derr) begin
            report("div_fault", {15'h0, div_fault_i}, {15'h0, want.derr});
          end
        end
        checked++;
      end
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        while (adjust_q.size() != 0) begin
          want = adjust_q.pop_front();
          report("missing result, expected ax", 16'h0, want.ax);
        end
      end
    end
    pending_o <= adjust_q.size();
    checked_o <= checked;
    errors_o  <= err_cnt;
  end

endmodule

// ----- tb/sv/bcd_adjust_unit_tb.sv -----
// top of the bcd adjust unit testbench: clock, reset, item stimulus,
// result stalls, watchdog and verdict
// depends on bcd_pkg, bcd_req_if, bcd_rsp_if, bcd_adjust_unit, bcd_adjust_unit_chk
module bcd_adjust_unit_tb;
  import bcd_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int RAND_ITEMS     = 950;
  localparam int QUIET_ITEMS    = 150;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic end_run;
  bit   quiet     = 1'b0;
  bit   hold_req  = 1'b0;
  bit   hold_done = 1'b0;
  int   sent      = 0;
  int   div_zero  = 0;
  int   unused    = 0;
  int   pending;
  int   checked;
  int   errors;
  int   dead_cycles = 0;

  always #6 clk_i = ~clk_i;

  bcd_req_if item_ch ();
  bcd_rsp_if result_ch ();

  bcd_adjust_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  bcd_adjust_unit_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (item_ch.valid),
    .req_ready_i (item_ch.ready),
    .action_i    (item_ch.action),
    .ax_i        (item_ch.ax_in),
    .flags_i     (item_ch.flags_in),
    .base_i      (item_ch.base),
    .rsp_valid_i (result_ch.valid),
    .rsp_ready_i (result_ch.ready),
    .ax_out_i    (result_ch.ax_out),
    .flag_bits_i (result_ch.flag_bits),
    .flag_mask_i (result_ch.flag_mask),
    .div_fault_i (result_ch.div_fault),
    .end_i       (end_run),
    .pending_o   (pending),
    .checked_o   (checked),
    .errors_o    (errors)
  );

  task automatic put_item(logic [2:0] op, logic [15:0] ax, logic [15:0] fl, logic [7:0] bs);
    item_ch.valid    <= 1'b1;
    item_ch.action   <= op;
    item_ch.ax_in    <= ax;
    item_ch.flags_in <= fl;
    item_ch.base     <= bs;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    sent++;
    if (op == ACT_AAM && bs == 8'h00) div_zero++;
    if (op == ACT_UNUSED_LO || op == ACT_UNUSED_HI) unused++;
  endtask

  task automatic pause_item(int cycles);
    item_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // result side stalls
  initial begin
    result_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (quiet) begin
        result_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) != 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", dead_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin
    logic [2:0]  op;
    logic [15:0] ax;
    logic [15:0] fl;
    logic [7:0]  bs;
    logic [3:0]  nib_hi;
    logic [3:0]  nib_lo;
    int unsigned pick;
    item_ch.valid    <= 1'b0;
    item_ch.action   <= '0;
    item_ch.ax_in    <= '0;
    item_ch.flags_in <= '0;
    item_ch.base     <= '0;
    end_run          <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    put_item(ACT_DAA, 16'h0000, 16'h0000, 8'h0A);
    put_item(ACT_DAA, 16'h129A, 16'h0000, 8'h0A);   // adjusted al above 9f
    put_item(ACT_DAA, 16'h00FA, FLAG_AF, 8'h0A);    // carry out of low step
    put_item(ACT_DAA, 16'hFF45, FLAG_CF, 8'h0A);    // carry in forces high step
    put_item(ACT_DAA, 16'hFFFF, 16'hFFFF, 8'hFF);
    put_item(ACT_DAS, 16'h0003, FLAG_AF, 8'h0A);    // borrow out of low step
    put_item(ACT_DAS, 16'h009A, 16'h0000, 8'h0A);   // original al above 99
    put_item(ACT_DAS, 16'h1234, FLAG_CF, 8'h0A);
    put_item(ACT_DAS, 16'hFFFF, 16'h0000, 8'h00);
    put_item(ACT_AAA, 16'hFFFF, 16'h0000, 8'h0A);   // whole ax wraps
    put_item(ACT_AAA, 16'h0005, FLAG_AF, 8'h0A);
    put_item(ACT_AAA, 16'h1234, 16'h0000, 8'h0A);
    put_item(ACT_AAS, 16'h0000, FLAG_AF, 8'h0A);    // whole ax wraps down
    put_item(ACT_AAS, 16'hFF0A, 16'hFFEF, 8'h0A);
    put_item(ACT_AAM, 16'h00FF, 16'hFFFF, 8'h00);   // divide by zero
    put_item(ACT_AAM, 16'hABFF, 16'h0000, 8'h0A);
    put_item(ACT_AAM, 16'h0000, 16'h0000, 8'hFF);
    put_item(ACT_AAM, 16'h00FF, 16'h0000, 8'h01);
    put_item(ACT_AAD, 16'hFFFF, 16'h0000, 8'hFF);   // product truncated
    put_item(ACT_AAD, 16'h0905, 16'h0000, 8'h0A);
    put_item(ACT_AAD, 16'h1234, 16'hFFFF, 8'h00);
    put_item(ACT_UNUSED_LO, 16'hBEEF, 16'hFFFF, 8'hFF);
    put_item(ACT_UNUSED_HI, 16'h0000, 16'h0000, 8'h00);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0) begin
        pause_item($urandom_range(1, 15));
      end
      pick = $urandom_range(0, 99);
      op   = (pick < 94) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
      ax   = 16'($urandom);
      fl   = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        bs = 8'h0A;
      end else if (pick == 4) begin
        bs = 8'h00;
      end else begin
        bs = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 2) == 0) begin
        nib_hi  = 4'($urandom_range(0, 9));
        nib_lo  = 4'($urandom_range(0, 9));
        ax[7:0] = {nib_hi, nib_lo};
      end
      put_item(op, ax, fl, bs);
    end
    item_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    end_run <= 1'b1;
    repeat (3) @(posedge clk_i);

    $display("covered %0d items over all six adjusts and the unused codes (%0d unused, %0d aam by zero)",
             sent, unused, div_zero);
    $display("checked %0d results under random stalls, one long result hold-off and a quiet tail",
             checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bcd_pkg.sv
rtl/bcd_if.sv
rtl/bcd_pre.sv
rtl/bcd_mid.sv
rtl/bcd_fin.sv
rtl/bcd_adjust_unit.sv
rtl/bcd_chk.sv
tb/sv/bcd_adjust_unit_chk.sv
tb/sv/bcd_adjust_unit_tb.sv
